>>> rtl/core/bdeq_pkg.sv
// Shared constants, operation codes and types of the bounded deque.
package bdeq_pkg;

  localparam int DEPTH     = 16;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int WORD_W    = 32;
  localparam int OP_W      = 3;
  localparam int CAP_W     = 5;
  localparam int CAP_RESET = 16;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [APB_AW-3:0] REG_CAPACITY = '0;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK       = 3'd4
  } op_t;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr_front;
    logic [AW-1:0]     raddr_rear;
  } mem_req_t;

endpackage

>>> rtl/core/bdeq_in_if.sv
// Input channel of the deque: operation and push word.
interface bdeq_in_if;
  import bdeq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

>>> rtl/core/bdeq_out_if.sv
// Result channel of the deque: status flags and end words.
interface bdeq_out_if;
  import bdeq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     success;
  logic signed [WORD_W-1:0] front_value;
  logic signed [WORD_W-1:0] rear_value;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, output success, output front_value, output rear_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input success, input front_value, input rear_value,
                  input is_empty, input is_full, output ready);
endinterface

>>> rtl/core/bdeq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bdeq_ram #(
  parameter int WIDTH   = 32,
  parameter int DEPTH_P = 16
) (
  input  logic                                             clk,
  input  logic                                             we,
  input  logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                                 wdata,
  input  logic                                             re,
  input  logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/bdeq_cfg.sv
// APB register block holding the deque capacity.
module bdeq_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bdeq_pkg::APB_AW-1:0]    paddr,
  input  logic [bdeq_pkg::APB_DW-1:0]    pwdata,
  output logic [bdeq_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  output logic [bdeq_pkg::CAP_W-1:0]     capacity
);
  import bdeq_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic             hit;

  assign hit      = (paddr[APB_AW-1:2] == REG_CAPACITY);
  assign pready   = 1'b1;
  assign capacity = cap_r;
  assign prdata   = hit ? APB_DW'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(CAP_RESET);
    end else if (psel && penable && pwrite && hit) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

endmodule

>>> rtl/core/bdeq_ctrl.sv
// Head/count bookkeeping, RAM sequencing and result register of the deque.
module bdeq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [bdeq_pkg::CAP_W-1:0]   capacity,
  bdeq_in_if.sink                      in_ch,
  bdeq_out_if.source                   out_ch,
  output bdeq_pkg::mem_req_t           mem_req,
  input  logic [bdeq_pkg::WORD_W-1:0]  rdata_front,
  input  logic [bdeq_pkg::WORD_W-1:0]  rdata_rear
);
  import bdeq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              ok_r, ok_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              success_r;
  logic [WORD_W-1:0] front_r, rear_r;
  logic              empty_r, full_r;

  logic [CW-1:0]     eff_cap;
  logic              can_push, can_pop, accept, load;
  logic [AW-1:0]     head_prev, head_next;

  // (head + off) mod DEPTH, valid for sums below 2*DEPTH
  function automatic logic [AW-1:0] ring_wrap(input logic [AW:0] sum);
    logic [AW:0] adj;
    adj = (sum >= (AW+1)'(DEPTH)) ? sum - (AW+1)'(DEPTH) : sum;
    return adj[AW-1:0];
  endfunction

  assign eff_cap   = (32'(capacity) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(capacity);
  assign can_push  = (count_r < eff_cap);
  assign can_pop   = (count_r != '0);
  assign head_prev = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
  assign head_next = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign load        = (state_r == S_LOAD) && (!out_valid_r || out_ch.ready);

  always_comb begin
    head_nxt          = head_r;
    count_nxt         = count_r;
    ok_nxt            = ok_r;
    mem_req.we        = 1'b0;
    mem_req.waddr     = head_r;
    mem_req.wdata     = in_ch.push_value;
    // reads go out in S_READ, the cycle after the write, so no same-entry overlap
    mem_req.re          = (state_r == S_READ);
    mem_req.raddr_front = head_r;
    mem_req.raddr_rear  = ring_wrap((AW+1)'(head_r) + (AW+1)'(count_r) - 1'b1);
    if (accept) begin
      ok_nxt = 1'b0;
      unique case (op_t'(in_ch.operation))
        OP_PUSH_FRONT: begin
          if (can_push) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = head_prev;
            head_nxt      = head_prev;
            count_nxt     = count_r + 1'b1;
            ok_nxt        = 1'b1;
          end
        end
        OP_PUSH_REAR: begin
          if (can_push) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = ring_wrap((AW+1)'(head_r) + (AW+1)'(count_r));
            count_nxt     = count_r + 1'b1;
            ok_nxt        = 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (can_pop) begin
            head_nxt  = head_next;
            count_nxt = count_r - 1'b1;
            ok_nxt    = 1'b1;
          end
        end
        OP_POP_REAR: begin
          if (can_pop) begin
            count_nxt = count_r - 1'b1;
            ok_nxt    = 1'b1;
          end
        end
        OP_PEEK: ok_nxt = 1'b1;
        default: ok_nxt = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_READ;
      S_READ:  state_nxt = S_LOAD;
      S_LOAD:  if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      ok_r        <= ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      success_r <= ok_r;
      front_r   <= (count_r == '0) ? EMPTY_WORD : rdata_front;
      rear_r    <= (count_r == '0) ? EMPTY_WORD : rdata_rear;
      empty_r   <= (count_r == '0);
      full_r    <= (count_r == eff_cap);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.success     = success_r;
  assign out_ch.front_value = front_r;
  assign out_ch.rear_value  = rear_r;
  assign out_ch.is_empty    = empty_r;
  assign out_ch.is_full     = full_r;

endmodule

>>> rtl/core/bounded_double_ended_queue.sv
// Bounded deque of signed 32-bit words in a ring RAM with head pointer and count.
// Result beat: input accepted in S_IDLE, RAM read in S_READ, result register loaded in S_LOAD.
// A new input beat is taken only in S_IDLE, once the previous one has loaded its result.
// A waiting result beat in the output register does not block the next input.
// Reset (sync, rst_n low): empty deque, head 0, capacity 16; RAM contents not cleared.
module bounded_double_ended_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  bdeq_in_if.sink                      in_ch,
  bdeq_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bdeq_pkg::APB_AW-1:0]  paddr,
  input  logic [bdeq_pkg::APB_DW-1:0]  pwdata,
  output logic [bdeq_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import bdeq_pkg::*;

  logic [CAP_W-1:0]  capacity;
  mem_req_t          mem_req;
  logic [WORD_W-1:0] rdata_front, rdata_rear;

  bdeq_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  bdeq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .capacity    (capacity),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mem_req     (mem_req),
    .rdata_front (rdata_front),
    .rdata_rear  (rdata_rear)
  );

  // two mirrored copies give one read port for each end of the ring
  bdeq_ram #(.WIDTH(WORD_W), .DEPTH_P(DEPTH)) u_ram_front (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr_front),
    .rdata (rdata_front)
  );

  bdeq_ram #(.WIDTH(WORD_W), .DEPTH_P(DEPTH)) u_ram_rear (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr_rear),
    .rdata (rdata_rear)
  );

endmodule

>>> test/tb_bounded_double_ended_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench of the bounded deque: random and directed operation beats.
module tb_bounded_double_ended_queue;
  import bdeq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned TAIL_CYCLES = 10;

  // operation codes outside the defined set
  localparam logic [OP_W-1:0] OP_UNUSED_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] word;
  } deq_item_t;

  typedef struct packed {
    logic                     success;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
  } deq_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_AW-1:0]  paddr = '0;
  logic [APB_DW-1:0]  pwdata = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  bdeq_in_if  in_ch();
  bdeq_out_if out_ch();

  bounded_double_ended_queue dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted deque contents
  logic signed [WORD_W-1:0] deq_words [DEPTH];
  int unsigned deq_head = 0;
  int unsigned deq_count = 0;
  int unsigned deq_cap = CAP_RESET;

  deq_item_t   pending_ops [$];
  deq_result_t expected_results [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_errors = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_refused = 0;
  int unsigned n_full = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  logic        hold_arm = 1'b0;
  logic        hold_used = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic deq_result_t deque_apply(logic [OP_W-1:0] op,
                                              logic signed [WORD_W-1:0] word);
    deq_result_t r;
    int unsigned lim;
    lim = (deq_cap > DEPTH) ? DEPTH : deq_cap;
    r.success = 1'b0;
    case (op)
      OP_PUSH_FRONT: if (deq_count < lim) begin
        deq_head = (deq_head + DEPTH - 1) % DEPTH;
        deq_words[deq_head] = word;
        deq_count++;
        r.success = 1'b1;
      end
      OP_PUSH_REAR: if (deq_count < lim) begin
        deq_words[(deq_head + deq_count) % DEPTH] = word;
        deq_count++;
        r.success = 1'b1;
      end
      OP_POP_FRONT: if (deq_count != 0) begin
        deq_head = (deq_head + 1) % DEPTH;
        deq_count--;
        r.success = 1'b1;
      end
      OP_POP_REAR: if (deq_count != 0) begin
        deq_count--;
        r.success = 1'b1;
      end
      OP_PEEK: r.success = 1'b1;
      default: r.success = 1'b0;
    endcase
    if (deq_count == 0) begin
      r.front_value = EMPTY_WORD;
      r.rear_value = EMPTY_WORD;
    end else begin
      r.front_value = deq_words[deq_head];
      r.rear_value = deq_words[(deq_head + deq_count - 1) % DEPTH];
    end
    r.is_empty = (deq_count == 0);
    r.is_full = (deq_count == lim);
    if (!r.success) n_refused++;
    if (r.is_full) n_full++;
    return r;
  endfunction

  function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      n_errors++;
    end
  endfunction

  // driver: offers pending operations, predicts each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.operation <= '0;
      in_ch.push_value <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.insert(expected_results.size(),
                                deque_apply(in_ch.operation, in_ch.push_value));
        n_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin : offer
          deq_item_t it;
          it = pending_ops[0];
          pending_ops.delete(0);
          in_ch.valid <= 1'b1;
          in_ch.operation <= it.op;
          in_ch.push_value <= it.word;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long result hold-off, counted here so the sender keeps pushing meanwhile
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_arm && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: compares each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin : take
        deq_result_t want;
        n_results++;
        if (expected_results.size() == 0) begin
          $error("result beat with no operation outstanding");
          n_errors++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          check_field("success", WORD_W'(want.success), WORD_W'(out_ch.success));
          check_field("front_value", want.front_value, out_ch.front_value);
          check_field("rear_value", want.rear_value, out_ch.rear_value);
          check_field("is_empty", WORD_W'(want.is_empty), WORD_W'(out_ch.is_empty));
          check_field("is_full", WORD_W'(want.is_full), WORD_W'(out_ch.is_full));
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_capacity(int unsigned value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_CAPACITY, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    deq_cap = value & ((1 << CAP_W) - 1);
  endtask

  task automatic add_op(logic [OP_W-1:0] op, logic signed [WORD_W-1:0] word);
    deq_item_t it;
    it.op = op;
    it.word = word;
    pending_ops.insert(pending_ops.size(), it);
  endtask

  // bursts that lean toward pushes, pops or neither, with some noise
  task automatic add_random_ops(int unsigned n);
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] word;
    int unsigned left, push_pct, r;
    left = 0;
    push_pct = 50;
    repeat (n) begin
      if (left == 0) begin
        case ($urandom_range(2))
          0: push_pct = 80;
          1: push_pct = 20;
          default: push_pct = 50;
        endcase
        left = $urandom_range(4, 16);
      end
      left--;
      r = $urandom_range(99);
      if (r < 4) begin
        case ($urandom_range(2))
          0: op = OP_UNUSED_5;
          1: op = OP_UNUSED_6;
          default: op = OP_UNUSED_7;
        endcase
      end else if (r < 10) begin
        op = OP_PEEK;
      end else if ($urandom_range(99) < push_pct) begin
        op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
      end else begin
        op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
      end
      case ($urandom_range(11))
        0: word = 32'sh7FFF_FFFF;
        1: word = 32'sh8000_0000;
        2: word = '0;
        3: word = '1;
        default: word = $urandom();
      endcase
      add_op(op, word);
    end
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(int unsigned cap, int unsigned idle, int unsigned stall,
                           int unsigned n);
    write_capacity(cap);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    add_random_ops(n);
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty deque: peek, refused pops, unused codes, then pushes at both ends
    add_op(OP_PEEK, 32'sh1234_5678);
    add_op(OP_POP_FRONT, '0);
    add_op(OP_POP_REAR, '0);
    add_op(OP_UNUSED_5, 32'sh1111_1111);
    add_op(OP_UNUSED_6, '0);
    add_op(OP_UNUSED_7, '1);
    add_op(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
    add_op(OP_PUSH_REAR, 32'sh8000_0000);
    add_op(OP_PUSH_FRONT, '0);
    add_op(OP_PUSH_REAR, '1);
    add_op(OP_PUSH_FRONT, 32'sh0000_0001);
    add_op(OP_UNUSED_7, 32'sh5A5A_5A5A);
    add_op(OP_PEEK, '0);
    drain();

    // capacity lowered under the count: entries kept, pushes refused until pops bring the count under it
    write_capacity(3);
    add_op(OP_PUSH_REAR, 32'sh2222_2222);
    add_op(OP_POP_FRONT, '0);
    add_op(OP_POP_REAR, '0);
    add_op(OP_PUSH_FRONT, 32'sh3333_3333);
    add_op(OP_POP_FRONT, '0);
    add_op(OP_PUSH_REAR, 32'shA5A5_A5A5);
    drain();

    write_capacity(1);
    add_op(OP_POP_REAR, '0);
    add_op(OP_POP_REAR, '0);
    add_op(OP_PUSH_FRONT, 32'sh4444_4444);
    add_op(OP_POP_FRONT, '0);
    drain();

    // zero capacity: full while empty, every push refused
    write_capacity(0);
    add_op(OP_PEEK, '0);
    add_op(OP_PUSH_REAR, 32'sh5555_5555);
    drain();

    // random part; the first phase also holds results off for a while
    write_capacity(16);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_random_ops(150);
    hold_arm <= 1'b1;
    drain();
    run_phase(31, 54, 0, 130);
    run_phase(3, 0, 54, 130);
    run_phase(1, 15, 15, 70);
    run_phase(0, 54, 54, 20);
    run_phase(9, 15, 15, 50);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d result beats for %0d operation beats; %0d refused, %0d at full.",
             n_results, n_accepted, n_refused, n_full);
    $display("Capacities 0, 1, 3, 9, 16 and 31, with sender gaps, result stalls and a long hold.");
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
